FILE: design/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Shared types and constants for the first-fit block allocator core.
// ============================================================================
package ffba_pkg;

    // Field widths of the request and result transfers.
    localparam int REQ_W    = 19;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 18;

    // Header entry layout: size in doublewords in bits 16..1, free mark in bit 0.
    localparam int HDR_W     = 17;
    localparam int SIZE_W    = 16;
    // A request of up to 2^19-1 bytes needs at most 17 bits in doublewords.
    localparam int NEED_DW_W = 17;

    // Default heap geometry.
    localparam int HEAP_BYTES_DEF  = 262144;
    localparam int CHUNK_BYTES_DEF = 4096;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NO_SPACE = 2'd2
    } status_t;

    // Sizing of one request, handed from the sizing unit to the walker.
    typedef struct packed {
        logic                 zero;     // request of zero bytes
        logic [NEED_DW_W-1:0] need_dw;  // rounded block size in doublewords
        logic [NEED_DW_W-1:0] grow_dw;  // heap growth if no block fits
    } req_info_t;

endpackage

FILE: design/first_fit_block_allocator_core.sv
// ============================================================================
// first_fit_block_allocator_core
// First-fit allocator over an implicit list of block headers held in one
// synchronous memory; walks the list, splits the block found or grows the heap.
// ============================================================================
// Latency: a zero request answers in the cycle after the transfer. Otherwise
// the walk reads the headers one by one from the first block, grows the heap
// if no free block fits, then writes the block header and, on a split, the tail.
// Throughput: one request at a time; a new request may be transferred in the
// cycle that the result strobe is high. The receiver cannot stall.
// Reset: control state clears at once; after reset the start-up state writes the
// first free block header, with busy held high.
module first_fit_block_allocator_core #(
    parameter int HEAP_BYTES  = ffba_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ffba_pkg::CHUNK_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffba_pkg::REQ_W-1:0]    request_bytes,
    output logic                          done,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    output logic [ffba_pkg::OFFSET_W-1:0] block_offset
);
    import ffba_pkg::*;

    // Geometry, all in doublewords.
    localparam int SLOTS       = HEAP_BYTES / 8;
    localparam int ADDR_W      = $clog2(SLOTS);
    localparam int P_W         = ADDR_W + 1;
    localparam int SUM_W       = ((P_W > NEED_DW_W) ? P_W : NEED_DW_W) + 1;
    localparam int CHUNK_SZ_DW = (CHUNK_BYTES / 4 + 1) / 2;
    localparam bit CHUNK_FITS  = (CHUNK_SZ_DW + 2) <= SLOTS;
    localparam int BRK_INIT    = CHUNK_FITS ? (CHUNK_SZ_DW + 2) : 2;
    localparam int FIRST_SLOT  = 2;

    localparam logic [P_W-1:0]    BRK_RESET  = P_W'(BRK_INIT);
    localparam logic [SUM_W-1:0]  SLOTS_V    = SUM_W'(SLOTS);
    localparam logic [ADDR_W-1:0] FIRST_ADDR = ADDR_W'(FIRST_SLOT);
    localparam logic [P_W-1:0]    FIRST_P    = P_W'(FIRST_SLOT);
    localparam logic [HDR_W-1:0]  INIT_HDR   = HDR_W'((CHUNK_SZ_DW % 65536) * 2 + 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_GROW  = 6'b001000,
        S_CARVE = 6'b010000,
        S_SPLIT = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic [P_W-1:0]       brk_reg, brk_next;
    logic [NEED_DW_W-1:0] need_reg, need_next;
    logic [NEED_DW_W-1:0] grow_reg, grow_next;
    logic [SIZE_W-1:0]    have_reg, have_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;

    logic [HDR_W-1:0]     hdr_mem [SLOTS];
    logic [HDR_W-1:0]     rd_data_reg;
    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [HDR_W-1:0]     wr_data;

    req_info_t            req_info;
    logic [SIZE_W-1:0]    blk_size;
    logic                 blk_free;
    logic                 blk_fits;
    logic [SUM_W-1:0]     walk_sum;
    logic [SUM_W-1:0]     grow_sum;
    logic [SUM_W-1:0]     tail_sum;
    logic [SIZE_W-1:0]    tail_size;
    logic                 do_split;
    logic [P_W+OFFSET_W+2:0] off_wide;

    // Request sizing.
    ffba_req_size #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_req_size (
        .request_bytes (request_bytes),
        .info          (req_info)
    );

    // Fields of the header just read, and the arithmetic of walk, growth and split.
    assign blk_size  = rd_data_reg[HDR_W-1:1];
    assign blk_free  = rd_data_reg[0];
    assign blk_fits  = need_reg <= NEED_DW_W'(blk_size);
    assign walk_sum  = SUM_W'(p_reg) + SUM_W'(blk_size);
    assign grow_sum  = SUM_W'(brk_reg) + SUM_W'(grow_reg);
    assign tail_sum  = SUM_W'(p_reg) + SUM_W'(need_reg);
    assign tail_size = have_reg - need_reg[SIZE_W-1:0];
    assign do_split  = NEED_DW_W'(have_reg) != need_reg;
    assign off_wide  = (P_W + OFFSET_W + 3)'({p_reg, 3'b000});

    // Sequencer: walk, grow and carve.
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        brk_next    = brk_reg;
        need_next   = need_reg;
        grow_next   = grow_reg;
        have_next   = have_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        offset_next = offset_reg;
        rd_en       = 1'b0;
        rd_addr     = walk_sum[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = p_reg[ADDR_W-1:0];
        wr_data     = {need_reg[SIZE_W-1:0], 1'b0};

        case (state_reg)
            S_INIT:
            begin
                wr_en      = CHUNK_FITS;
                wr_addr    = FIRST_ADDR;
                wr_data    = INIT_HDR;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    need_next = req_info.need_dw;
                    grow_next = req_info.grow_dw;
                    p_next    = FIRST_P;
                    if (req_info.zero)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ZERO;
                        offset_next = '0;
                    end
                    else if (FIRST_P < brk_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = FIRST_ADDR;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_GROW;
                    end
                end
            end
            S_CHECK:
            begin
                if (blk_size == '0)
                begin
                    state_next = S_GROW;
                end
                else if (blk_free && blk_fits)
                begin
                    have_next  = blk_size;
                    state_next = S_CARVE;
                end
                else if (walk_sum < SUM_W'(brk_reg))
                begin
                    rd_en      = 1'b1;
                    p_next     = walk_sum[P_W-1:0];
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                if (grow_sum > SLOTS_V)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NO_SPACE;
                    offset_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    p_next     = brk_reg;
                    have_next  = grow_reg[SIZE_W-1:0];
                    brk_next   = grow_sum[P_W-1:0];
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                wr_en = 1'b1;
                if (do_split)
                begin
                    wr_data    = {need_reg[SIZE_W-1:0], 1'b0};
                    state_next = S_SPLIT;
                end
                else
                begin
                    wr_data     = {have_reg, 1'b0};
                    done_next   = 1'b1;
                    status_next = ST_GRANTED;
                    offset_next = off_wide[OFFSET_W-1:0];
                    state_next  = S_IDLE;
                end
            end
            S_SPLIT:
            begin
                wr_en       = 1'b1;
                wr_addr     = tail_sum[ADDR_W-1:0];
                wr_data     = {tail_size, 1'b1};
                done_next   = 1'b1;
                status_next = ST_GRANTED;
                offset_next = off_wide[OFFSET_W-1:0];
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            brk_reg    <= BRK_RESET;
            done_reg   <= 1'b0;
            status_reg <= ST_GRANTED;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            brk_reg    <= brk_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        need_reg <= need_next;
        grow_reg <= grow_next;
        have_reg <= have_next;
    end

    // Header store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    // Outputs.
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign block_offset = offset_reg;

    // A result only follows the end of a request's work.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_CARVE || state_reg == S_SPLIT ||
                           state_reg == S_GROW || (state_reg == S_IDLE && start)))
        else $error("result strobe without a finished request");

    // A refused request carries no offset.
    a_refused_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_GRANTED) |-> (offset_reg == '0))
        else $error("non-zero offset on a refused request");

    // The heap break never passes the end of the store.
    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(brk_reg) <= SLOTS_V)
        else $error("heap break beyond the header store");

    // The walk reads only headers inside the heap.
    a_read_inside: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (P_W'(rd_addr) < brk_reg))
        else $error("header read at or beyond the heap break");

    // Headers are written only at start-up or while carving a block.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_INIT || state_reg == S_CARVE || state_reg == S_SPLIT))
        else $error("header write outside start-up or carving");

endmodule

FILE: design/ffba_req_size.sv
// ============================================================================
// ffba_req_size
// Rounds a payload byte count to a block size in doublewords and works out
// the amount by which the heap grows when no free block fits.
// ============================================================================
module ffba_req_size #(
    parameter int CHUNK_BYTES = ffba_pkg::CHUNK_BYTES_DEF
) (
    input  logic [ffba_pkg::REQ_W-1:0] request_bytes,
    output ffba_pkg::req_info_t        info
);
    import ffba_pkg::*;

    // Chunk size rounded up to a whole doubleword, and the threshold above
    // which the request itself sets the growth.
    localparam int CHUNK_SZ_DW = (CHUNK_BYTES / 4 + 1) / 2;
    localparam int CHUNK_FLOOR_DW = CHUNK_BYTES / 8;
    localparam logic [NEED_DW_W-1:0] CHUNK_SZ_V    = NEED_DW_W'(CHUNK_SZ_DW);
    localparam logic [NEED_DW_W-1:0] CHUNK_FLOOR_V = NEED_DW_W'(CHUNK_FLOOR_DW);

    logic [REQ_W:0]       padded;
    logic [NEED_DW_W-1:0] need_dw;

    // Header word plus round-up: (n + 4 + 7) / 8, which also gives one
    // doubleword for requests of one to four bytes.
    assign padded  = {1'b0, request_bytes} + (REQ_W + 1)'(11);
    assign need_dw = padded[REQ_W:3];

    // Output struct.
    assign info.zero    = (request_bytes == '0);
    assign info.need_dw = need_dw;
    assign info.grow_dw = (need_dw > CHUNK_FLOOR_V) ? need_dw : CHUNK_SZ_V;

endmodule

FILE: bench/allocation_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// allocation_checker
// Watches the request and result transfers of the allocator core, works out
// each result from its own copy of the header list and the heap break, and
// compares every result field by field with the oldest expected one.
// ============================================================================
module allocation_checker #(
    parameter int HEAP_BYTES  = ffba_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ffba_pkg::CHUNK_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [ffba_pkg::REQ_W-1:0]    request_bytes,
    input  logic                          done,
    input  logic [ffba_pkg::STATUS_W-1:0] status,
    input  logic [ffba_pkg::OFFSET_W-1:0] block_offset,
    output int                            fail_count,
    output int                            outstanding
);
    import ffba_pkg::*;

    localparam int SLOTS       = HEAP_BYTES / 8;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        status_t               st;
        logic [OFFSET_W-1:0]   off;
    } alloc_result_t;

    // Own copy of the allocator state: one header per doubleword and the break.
    logic [HDR_W-1:0] heap_hdr [SLOTS];
    int unsigned      heap_end;
    int unsigned      first_block;

    alloc_result_t    expected_grants [$];
    alloc_result_t    oldest;

    // Writes the header of the block whose payload starts at byte offset off.
    function automatic void write_header(input int unsigned off, input int unsigned bytes,
                                         input bit is_free);
        logic [SIZE_W-1:0] dwords;
        dwords = SIZE_W'(bytes / 8);
        heap_hdr[(off / 8) % SLOTS] = {dwords, is_free};
    endfunction

    function automatic int unsigned header_bytes(input int unsigned off);
        return heap_hdr[(off / 8) % SLOTS][HDR_W-1:1] * 8;
    endfunction

    // Appends a free block at the break, rounded up to a whole doubleword.
    function automatic bit append_free_block(input int unsigned bytes,
                                             output int unsigned at);
        int unsigned words;
        int unsigned sz;
        words = bytes / 4;
        if (words % 2 != 0)
            words++;
        sz = words * 4;
        at = heap_end;
        if (heap_end > HEAP_BYTES || sz > HEAP_BYTES - heap_end)
            return 1'b0;
        write_header(heap_end, sz, 1'b1);
        heap_end += sz;
        return 1'b1;
    endfunction

    // First-fit walk, growth on a miss, then a split or a whole-block take.
    function automatic alloc_result_t predict_allocation(input logic [REQ_W-1:0] bytes);
        int unsigned   need;
        int unsigned   p;
        int unsigned   sz;
        int unsigned   have;
        int unsigned   ext;
        bit            hit;
        bit            stop;
        alloc_result_t r;
        r.st  = ST_NO_SPACE;
        r.off = '0;
        if (bytes == 0)
        begin
            r.st = ST_ZERO;
            return r;
        end
        need = (bytes <= 4) ? 8 : 8 * ((bytes + 11) / 8);

        p    = 8;
        hit  = 1'b0;
        stop = 1'b0;
        while (!hit && !stop && p < heap_end)
        begin
            sz = header_bytes(p);
            // A zero-size header ends the walk.
            if (sz == 0)
                stop = 1'b1;
            else if (heap_hdr[(p / 8) % SLOTS][0] && need <= sz)
                hit = 1'b1;
            else
                p += sz;
        end

        if (!hit)
        begin
            ext = (need > CHUNK_BYTES) ? need : CHUNK_BYTES;
            if (!append_free_block(ext, p))
                return r;
        end

        // Split only when a usable tail of at least one doubleword remains.
        have = header_bytes(p);
        if (have - need >= 8)
        begin
            write_header(p, need, 1'b0);
            write_header(p + need, have - need, 1'b1);
        end
        else
        begin
            write_header(p, have, 1'b0);
        end
        r.st  = ST_GRANTED;
        r.off = p[OFFSET_W-1:0];
        return r;
    endfunction

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Results are compared before the request of the same edge is queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_grants.delete();
            heap_end = 16;
            write_header(8, 8, 1'b0);
            void'(append_free_block(CHUNK_BYTES, first_block));
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: unexpected result: status %0d offset %0d",
                                 $realtime, status, block_offset);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_grants.pop_front();
                    if (status !== oldest.st || block_offset !== oldest.off)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("%0t: mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                                     $realtime, oldest.st, status, oldest.off, block_offset);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_grants.push_back(predict_allocation(request_bytes));
            outstanding <= expected_grants.size();
        end
    end

endmodule

FILE: bench/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_first_fit_block_allocator_core
// Drives allocation requests into the allocator core, first a directed run
// through rounding, splitting, whole-block takes, heap growth and exhaustion,
// then random sizes with random idle gaps; the checker beside the core
// predicts and compares every result, and this module gives the verdict.
// ============================================================================
module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam int REQ_LIMIT       = 262144;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int LIMIT_CYCLES    = 20_000_000;
    localparam int DRAIN_CYCLES    = 100;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [REQ_W-1:0]    request_bytes;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] block_offset;

    int                  fail_count;
    int                  outstanding;
    int                  cycle_count;
    int                  burst_left;
    int                  i;
    int unsigned         size_class;
    logic [REQ_W-1:0]    req;

    first_fit_block_allocator_core #(
        .HEAP_BYTES  (HEAP_BYTES_DEF),
        .CHUNK_BYTES (CHUNK_BYTES_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request_bytes (request_bytes),
        .done          (done),
        .status        (status),
        .block_offset  (block_offset)
    );

    allocation_checker #(
        .HEAP_BYTES  (HEAP_BYTES_DEF),
        .CHUNK_BYTES (CHUNK_BYTES_DEF)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request_bytes (request_bytes),
        .done          (done),
        .status        (status),
        .block_offset  (block_offset),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Holds start until the core takes the transfer, then may idle for a random gap.
    // Start may rise while the core is busy, so gaps land on every phase.
    task automatic issue_request(input logic [REQ_W-1:0] bytes);
        int          gap;
        int unsigned roll;
        start         <= 1'b1;
        request_bytes <= bytes;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        gap  = 0;
        roll = $urandom_range(0, 99);
        if (burst_left > 0)
            burst_left--;
        else if (roll < 4)
            burst_left = $urandom_range(10, 40);
        else if (roll < 45)
            gap = 0;
        else if (roll < 80)
            gap = $urandom_range(1, 3);
        else if (roll < 96)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(30, 120);

        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        request_bytes = '0;
        burst_left    = 0;
        cycle_count   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Rounding at the small end, all carved from the first chunk.
        issue_request(19'd0);
        issue_request(19'd1);
        issue_request(19'd4);
        issue_request(19'd5);
        issue_request(19'd12);
        issue_request(19'd13);
        issue_request(19'd20);
        // Larger than a chunk: the heap grows by exactly the block size.
        issue_request(19'd5000);
        // Leaves a tail in the first chunk that the next request fills whole.
        issue_request(19'd2984);
        issue_request(19'd1004);
        // No free block left: one growth taken whole, one growth split.
        issue_request(19'd4092);
        issue_request(19'd3);
        issue_request(19'd0);
        // Out of heap space; the break must stay where it was.
        issue_request(19'd250000);
        issue_request(19'd262144);
        issue_request(19'h3FFFF);
        issue_request(19'd7);

        // Random sizes, weighted towards blocks that keep the heap growing.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            size_class = $urandom_range(0, 99);
            if (size_class < 3)
                req = '0;
            else if (size_class < 20)
                req = REQ_W'($urandom_range(1, 24));
            else if (size_class < 48)
                req = REQ_W'($urandom_range(25, 400));
            else if (size_class < 80)
                req = REQ_W'($urandom_range(401, 3000));
            else if (size_class < 94)
                req = REQ_W'($urandom_range(3001, 16000));
            else if (size_class < 97)
                req = REQ_W'($urandom_range(16001, 40000));
            else
                req = REQ_W'($urandom_range(200000, REQ_LIMIT));
            issue_request(req);
        end
        start <= 1'b0;

        // Wait for every expected result, then watch for strays.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
